@@ sv/nstr_pkg.sv @@
`timescale 1ns / 1ps
package nstr_pkg;

	localparam logic [62:0] MASK63  = '1;
	localparam logic [15:0] OVF_MAX = 16'hFFFF;

	localparam logic CFG_ATTACHED      = 1'b0;
	localparam logic CFG_DEFAULT_COLOR = 1'b1;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_END   = 2'd1,
		OP_FRAME = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_DISABLED   = 3'd1,
		ST_OVERFLOW   = 3'd2,
		ST_UNMATCHED  = 3'd3,
		ST_RANGE      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SPAN,
		S_ACC,
		S_DONE
	} state_t;

	typedef enum logic {
		ALU_SUB_CLAMP,
		ALU_ADD_SAT
	} alu_op_t;

	typedef struct packed {
		logic wr_all;
		logic wr_span;
		logic rd;
	} mem_ctl_t;

endpackage

@@ sv/nstr_alu.sv @@
`timescale 1ns / 1ps
module nstr_alu (
	input  nstr_pkg::alu_op_t op,
	input  logic [62:0]       a,
	input  logic [62:0]       b,
	output logic [62:0]       y
);

	logic [63:0] sum;
	logic [63:0] diff;

	assign sum  = {1'b0, a} + {1'b0, b};
	assign diff = {1'b0, a} - {1'b0, b};

	always_comb begin
		case (op)
			nstr_pkg::ALU_SUB_CLAMP: y = diff[63] ? 63'd0 : diff[62:0];
			nstr_pkg::ALU_ADD_SAT:   y = sum[63] ? nstr_pkg::MASK63 : sum[62:0];
			default:                 y = diff[62:0];
		endcase
	end

endmodule

@@ sv/nstr_section_mem.sv @@
`timescale 1ns / 1ps
module nstr_section_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int PW    = 7
) (
	input  logic                 clk,
	input  nstr_pkg::mem_ctl_t   ctl,
	input  logic [AW-1:0]        waddr,
	input  logic [AW-1:0]        raddr,
	input  logic [62:0]          wbegin,
	input  logic [63:0]          wspan,
	input  logic [31:0]          wcolor,
	input  logic signed [PW-1:0] wparent,
	output logic [62:0]          rbegin,
	output logic [63:0]          rspan,
	output logic [31:0]          rcolor,
	output logic signed [PW-1:0] rparent
);

	logic [62:0]          begin_mem  [DEPTH];
	logic [63:0]          span_mem   [DEPTH];
	logic [31:0]          color_mem  [DEPTH];
	logic signed [PW-1:0] parent_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_all) begin
			begin_mem[waddr]  <= wbegin;
			color_mem[waddr]  <= wcolor;
			parent_mem[waddr] <= wparent;
		end
		if (ctl.wr_all || ctl.wr_span) begin
			span_mem[waddr] <= wspan;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rbegin  <= begin_mem[raddr];
			rspan   <= span_mem[raddr];
			rcolor  <= color_mem[raddr];
			rparent <= parent_mem[raddr];
		end
	end

endmodule

@@ sv/nested_section_time_recorder_core.sv @@
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid/in_ready    operation timestamp use_own_color color entry_index
// out      out_valid/out_ready  status read_begin read_span read_color read_parent
//                               last_count last_total_span
// cfg      cfg_we               cfg_index cfg_wdata
//
// One item at a time: accept, an execute step, then a load of the result
// register; an end that closes a section adds a span step (begin read from the
// section RAM, one adder in clamp-subtract mode), and a root close adds an
// accumulate step for the saturating total on the same adder.
// A new beat is taken while the previous result waits in the output register;
// the result stage stalls until that register is free.
// arst_n clears control state; the section RAM needs no clearing.
module nested_section_time_recorder_core #(
	parameter int SECTIONS = 64
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [62:0]        timestamp,
	input  logic               use_own_color,
	input  logic [31:0]        color,
	input  logic [5:0]         entry_index,

	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [62:0]        read_begin,
	output logic signed [63:0] read_span,
	output logic [31:0]        read_color,
	output logic signed [6:0]  read_parent,
	output logic [6:0]         last_count,
	output logic [62:0]        last_total_span
);

	localparam int IDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int CNT_W = $clog2(SECTIONS + 1);
	localparam int PW    = IDX_W + 1;
	localparam int DEPTH = 2 * SECTIONS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

	nstr_pkg::state_t    state_q, state_d;
	nstr_pkg::op_t       op_q;
	nstr_pkg::status_t   status_q;
	nstr_pkg::mem_ctl_t  mem_ctl;
	nstr_pkg::alu_op_t   alu_op;

	logic [62:0]          time_q;
	logic                 own_q;
	logic [31:0]          color_q;
	logic [5:0]           ridx_q;

	logic                 attached_q;
	logic [31:0]          def_color_q;

	logic                 half_q;
	logic signed [PW-1:0] top_q;
	logic [CNT_W-1:0]     count_q [2];
	logic [15:0]          ovf_q;
	logic [62:0]          root_q [2];
	logic                 enabled_q;
	logic [62:0]          span_q;
	logic                 out_valid_q;

	logic [AW-1:0]        waddr, raddr;
	logic [63:0]          wspan;
	logic [62:0]          alu_a, alu_b, alu_y;
	logic [62:0]          rbegin;
	logic [63:0]          rspan;
	logic [31:0]          rcolor;
	logic signed [PW-1:0] rparent;

	logic                 fin;
	logic                 full;
	logic                 top_open;
	logic                 in_range;
	logic                 done_fire;
	logic                 read_ok;

	function automatic logic [AW-1:0] slot(input logic hf, input logic [IDX_W-1:0] idx);
		slot = hf ? (AW'(idx) + AW'(SECTIONS)) : AW'(idx);
	endfunction

	assign fin       = ~half_q;
	assign full      = count_q[half_q] == CNT_W'(SECTIONS);
	assign top_open  = ~top_q[PW-1];
	assign in_range  = CMP_W'(ridx_q) < CMP_W'(count_q[fin]);
	assign done_fire = (state_q == nstr_pkg::S_DONE) && (!out_valid_q || out_ready);
	assign read_ok   = (op_q == nstr_pkg::OP_READ) && (status_q == nstr_pkg::ST_OK);
	assign in_ready  = state_q == nstr_pkg::S_IDLE;
	assign out_valid = out_valid_q;
	assign wspan     = mem_ctl.wr_all ? '1 : {1'b0, alu_y};

	nstr_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	nstr_section_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.PW    (PW)
	) u_mem (
		.clk     (clk),
		.ctl     (mem_ctl),
		.waddr   (waddr),
		.raddr   (raddr),
		.wbegin  (time_q),
		.wspan   (wspan),
		.wcolor  (own_q ? color_q : def_color_q),
		.wparent (top_q),
		.rbegin  (rbegin),
		.rspan   (rspan),
		.rcolor  (rcolor),
		.rparent (rparent)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nstr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mem_ctl = '0;
		alu_op  = nstr_pkg::ALU_SUB_CLAMP;
		alu_a   = time_q;
		alu_b   = rbegin;
		waddr   = slot(half_q, top_q[IDX_W-1:0]);
		raddr   = slot(half_q, top_q[IDX_W-1:0]);
		case (state_q)
			nstr_pkg::S_IDLE: begin
				if (in_valid) state_d = nstr_pkg::S_EXEC;
			end
			nstr_pkg::S_EXEC: begin
				state_d = nstr_pkg::S_DONE;
				case (op_q)
					nstr_pkg::OP_BEGIN: begin
						if (enabled_q && !full) begin
							mem_ctl.wr_all = 1'b1;
							waddr = slot(half_q, count_q[half_q][IDX_W-1:0]);
						end
					end
					nstr_pkg::OP_END: begin
						if (enabled_q && ovf_q == '0 && top_open) begin
							mem_ctl.rd = 1'b1;
							state_d = nstr_pkg::S_SPAN;
						end
					end
					nstr_pkg::OP_READ: begin
						if (in_range) begin
							mem_ctl.rd = 1'b1;
							raddr = slot(fin, IDX_W'(ridx_q));
						end
					end
					default: ;
				endcase
			end
			nstr_pkg::S_SPAN: begin
				mem_ctl.wr_span = 1'b1;
				state_d = rparent[PW-1] ? nstr_pkg::S_ACC : nstr_pkg::S_DONE;
			end
			nstr_pkg::S_ACC: begin
				alu_op  = nstr_pkg::ALU_ADD_SAT;
				alu_a   = root_q[half_q];
				alu_b   = span_q;
				state_d = nstr_pkg::S_DONE;
			end
			nstr_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) state_d = nstr_pkg::S_IDLE;
			end
			default: state_d = nstr_pkg::S_IDLE;
		endcase
	end

	// hold the beat for the whole item
	always_ff @(posedge clk) begin
		if (state_q == nstr_pkg::S_IDLE && in_valid) begin
			op_q    <= nstr_pkg::op_t'(operation);
			time_q  <= timestamp;
			own_q   <= use_own_color;
			color_q <= color;
			ridx_q  <= entry_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attached_q  <= 1'b0;
			def_color_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				nstr_pkg::CFG_ATTACHED:      attached_q  <= cfg_wdata[0];
				nstr_pkg::CFG_DEFAULT_COLOR: def_color_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q     <= 1'b0;
			top_q      <= '1;
			count_q[0] <= '0;
			count_q[1] <= '0;
			ovf_q      <= '0;
			root_q[0]  <= '0;
			root_q[1]  <= '0;
			enabled_q  <= 1'b0;
			status_q   <= nstr_pkg::ST_OK;
		end else begin
			case (state_q)
				nstr_pkg::S_EXEC: begin
					status_q <= nstr_pkg::ST_OK;
					case (op_q)
						nstr_pkg::OP_BEGIN: begin
							if (!enabled_q) begin
								status_q <= nstr_pkg::ST_DISABLED;
							end else if (full) begin
								if (ovf_q != nstr_pkg::OVF_MAX) ovf_q <= ovf_q + 16'd1;
								status_q <= nstr_pkg::ST_OVERFLOW;
							end else begin
								top_q <= {1'b0, count_q[half_q][IDX_W-1:0]};
								count_q[half_q] <= count_q[half_q] + CNT_W'(1);
							end
						end
						nstr_pkg::OP_END: begin
							if (!enabled_q) begin
								status_q <= nstr_pkg::ST_DISABLED;
							end else if (ovf_q != '0) begin
								ovf_q    <= ovf_q - 16'd1;
								status_q <= nstr_pkg::ST_OVERFLOW;
							end else if (!top_open) begin
								status_q <= nstr_pkg::ST_UNMATCHED;
							end
						end
						nstr_pkg::OP_FRAME: begin
							half_q       <= ~half_q;
							top_q        <= '1;
							ovf_q        <= '0;
							count_q[fin] <= '0;
							root_q[fin]  <= '0;
							enabled_q    <= attached_q;
						end
						nstr_pkg::OP_READ: begin
							if (!in_range) status_q <= nstr_pkg::ST_RANGE;
						end
						default: ;
					endcase
				end
				nstr_pkg::S_SPAN: top_q <= rparent;
				nstr_pkg::S_ACC:  root_q[half_q] <= alu_y;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == nstr_pkg::S_SPAN) span_q <= alu_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			status          <= status_q;
			read_begin      <= read_ok ? rbegin : '0;
			read_span       <= read_ok ? rspan : '0;
			read_color      <= read_ok ? rcolor : '0;
			read_parent     <= read_ok ? 7'(rparent) : '0;
			last_count      <= 7'(count_q[fin]);
			last_total_span <= root_q[fin];
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("beat accepted while an item is in flight");

	a_top_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		top_open |-> CNT_W'(top_q[IDX_W-1:0]) < count_q[half_q])
		else $error("open section index beyond section count");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q != '0 |-> count_q[half_q] == CNT_W'(SECTIONS))
		else $error("overflow depth with a table that is not full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[0] <= CNT_W'(SECTIONS) && count_q[1] <= CNT_W'(SECTIONS))
		else $error("section count beyond table size");

	a_acc_after_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nstr_pkg::S_ACC |-> $past(state_q) == nstr_pkg::S_SPAN)
		else $error("root total update without a span step");

endmodule

@@ test/section_recorder_checker.sv @@
`timescale 1ns / 1ps
module section_recorder_checker #(
	parameter int SECTIONS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [62:0]        timestamp,
	input  logic               use_own_color,
	input  logic [31:0]        color,
	input  logic [5:0]         entry_index,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [2:0]         status,
	input  logic [62:0]        read_begin,
	input  logic signed [63:0] read_span,
	input  logic [31:0]        read_color,
	input  logic signed [6:0]  read_parent,
	input  logic [6:0]         last_count,
	input  logic [62:0]        last_total_span,
	output int                 pending,
	output int                 fail_count
);

	typedef struct packed {
		nstr_pkg::status_t status;
		logic [62:0]       begin_time;
		logic [63:0]       span;
		logic [31:0]       color;
		logic [6:0]        parent;
		logic [6:0]        count;
		logic [62:0]       total;
	} section_result_t;

	logic [62:0] begin_mem [2*SECTIONS];
	logic [63:0] span_mem [2*SECTIONS];
	logic [31:0] color_mem [2*SECTIONS];
	int          parent_mem [2*SECTIONS];
	int          active_half;
	int          top_section;
	int          section_cnt [2];
	logic [15:0] overflow_cnt;
	logic [62:0] root_sum [2];
	bit          enabled;
	bit          attached;
	logic [31:0] default_color;

	section_result_t pending_results [$];
	int errors = 0;

	assign fail_count = errors;

	function automatic section_result_t record_item(nstr_pkg::op_t op, logic [62:0] ts,
			logic own, logic [31:0] col, logic [5:0] idx);
		section_result_t r;
		int h;
		int fin;
		int s;
		logic [63:0] span;
		logic [63:0] sum;
		r = '0;
		r.status = nstr_pkg::ST_OK;
		h = active_half;
		case (op)
			nstr_pkg::OP_BEGIN: begin
				if (!enabled) begin
					r.status = nstr_pkg::ST_DISABLED;
				end else if (section_cnt[h] >= SECTIONS) begin
					if (overflow_cnt < nstr_pkg::OVF_MAX)
						overflow_cnt++;
					r.status = nstr_pkg::ST_OVERFLOW;
				end else begin
					s = h * SECTIONS + section_cnt[h];
					begin_mem[s] = ts;
					span_mem[s] = '1;
					color_mem[s] = own ? col : default_color;
					parent_mem[s] = top_section;
					top_section = section_cnt[h];
					section_cnt[h]++;
				end
			end
			nstr_pkg::OP_END: begin
				if (!enabled) begin
					r.status = nstr_pkg::ST_DISABLED;
				end else if (overflow_cnt != 0) begin
					overflow_cnt--;
					r.status = nstr_pkg::ST_OVERFLOW;
				end else if (top_section < 0) begin
					r.status = nstr_pkg::ST_UNMATCHED;
				end else begin
					s = h * SECTIONS + top_section;
					span = (ts < begin_mem[s]) ? 64'd0 : {1'b0, ts - begin_mem[s]};
					span_mem[s] = span;
					if (parent_mem[s] < 0) begin
						sum = {1'b0, root_sum[h]} + span;
						root_sum[h] = sum[63] ? nstr_pkg::MASK63 : sum[62:0];
					end
					top_section = parent_mem[s];
				end
			end
			nstr_pkg::OP_FRAME: begin
				active_half = 1 - h;
				top_section = -1;
				overflow_cnt = '0;
				section_cnt[active_half] = 0;
				root_sum[active_half] = '0;
				enabled = attached;
			end
			default: begin
				fin = 1 - h;
				if (idx >= section_cnt[fin]) begin
					r.status = nstr_pkg::ST_RANGE;
				end else begin
					s = fin * SECTIONS + idx;
					r.begin_time = begin_mem[s];
					r.span = span_mem[s];
					r.color = color_mem[s];
					r.parent = 7'(parent_mem[s]);
				end
			end
		endcase
		fin = 1 - active_half;
		r.count = 7'(section_cnt[fin]);
		r.total = root_sum[fin];
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		section_result_t want;
		section_result_t got;
		if (!arst_n) begin
			active_half = 0;
			top_section = -1;
			section_cnt[0] = 0;
			section_cnt[1] = 0;
			overflow_cnt = '0;
			root_sum[0] = '0;
			root_sum[1] = '0;
			enabled = 1'b0;
			attached = 1'b0;
			default_color = '0;
			pending_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == nstr_pkg::CFG_ATTACHED)
					attached = cfg_wdata[0];
				else
					default_color = cfg_wdata;
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual status %0d",
						$time, status);
					errors++;
				end else begin
					want = pending_results.pop_front();
					got.status = nstr_pkg::status_t'(status);
					got.begin_time = read_begin;
					got.span = read_span;
					got.color = read_color;
					got.parent = read_parent;
					got.count = last_count;
					got.total = last_total_span;
					check_field("status", want.status, got.status);
					check_field("read_begin", want.begin_time, got.begin_time);
					check_field("read_span", want.span, got.span);
					check_field("read_color", want.color, got.color);
					check_field("read_parent", want.parent, got.parent);
					check_field("last_count", want.count, got.count);
					check_field("last_total_span", want.total, got.total);
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(record_item(nstr_pkg::op_t'(operation),
					timestamp, use_own_color, color, entry_index));
		end
		pending = pending_results.size();
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int ITEMS        = 400;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic               cfg_index;
	logic [31:0]        cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         operation;
	logic [62:0]        timestamp;
	logic               use_own_color;
	logic [31:0]        color;
	logic [5:0]         entry_index;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         status;
	logic [62:0]        read_begin;
	logic signed [63:0] read_span;
	logic [31:0]        read_color;
	logic signed [6:0]  read_parent;
	logic [6:0]         last_count;
	logic [62:0]        last_total_span;

	int          pending;
	int          fail_count;
	int          cycles = 0;
	int          sent = 0;
	int          calm_tx = 0;
	bit          hold_req = 1'b0;
	logic [62:0] now_tick;
	int          live_count = 0;
	int          done_count = 0;
	bit          live_on = 1'b0;
	bit          attached_now = 1'b0;

	nested_section_time_recorder_core i_dut (.*);

	section_recorder_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("nested_section_time_recorder_core regression: fail");
			$finish;
		end
	end

	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic logic [62:0] rand63();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[62:0];
	endfunction

	function automatic logic [62:0] next_tick();
		if ($urandom_range(0, 30) == 0)
			now_tick += rand63() >> $urandom_range(1, 62);
		else
			now_tick += $urandom_range(0, 2000);
		return now_tick;
	endfunction

	function automatic logic [5:0] pick_index();
		if (done_count > 0 && $urandom_range(0, 3) != 0)
			return 6'($urandom_range(0, done_count - 1));
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic logic [31:0] pick_color();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send(nstr_pkg::op_t op, logic [62:0] ts, logic own, logic [31:0] col,
			logic [5:0] idx);
		int gap;
		gap = draw_wait(calm_tx);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		timestamp <= ts;
		use_own_color <= own;
		color <= col;
		entry_index <= idx;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (op == nstr_pkg::OP_BEGIN && live_on && live_count < 64)
			live_count++;
		if (op == nstr_pkg::OP_FRAME) begin
			done_count = live_count;
			live_count = 0;
			live_on = attached_now;
		end
	endtask

	task automatic send_noise(nstr_pkg::op_t op, logic [62:0] ts);
		send(op, ts, 1'($urandom_range(0, 1)), $urandom, 6'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic set_profiler(bit att, logic [31:0] dc);
		cfg_we <= 1'b1;
		cfg_index <= nstr_pkg::CFG_ATTACHED;
		cfg_wdata <= {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, att};
		@(posedge clk);
		cfg_index <= nstr_pkg::CFG_DEFAULT_COLOR;
		cfg_wdata <= dc;
		@(posedge clk);
		cfg_we <= 1'b0;
		attached_now = att;
	endtask

	task automatic run_frame(int len);
		int depth;
		int pick;
		depth = 0;
		send_noise(nstr_pkg::OP_FRAME, rand63());
		repeat (len) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_noise(nstr_pkg::OP_BEGIN, next_tick());
				depth++;
			end else if (pick < 85) begin
				send_noise(nstr_pkg::OP_END, next_tick());
				if (depth > 0)
					depth--;
			end else if (pick < 93) begin
				send(nstr_pkg::OP_READ, rand63(), 1'($urandom_range(0, 1)), $urandom,
					pick_index());
			end else if (pick < 97) begin
				send_noise(nstr_pkg::OP_END, rand63());
				if (depth > 0)
					depth--;
			end else begin
				send_noise(nstr_pkg::OP_BEGIN, rand63());
				depth++;
			end
		end
		if ($urandom_range(0, 3) != 0) begin
			while (depth > 0) begin
				send_noise(nstr_pkg::OP_END, next_tick());
				depth--;
			end
		end
	endtask

	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		begin
			int calm_rx;
			int stall;
			calm_rx = 0;
			forever begin
				stall = draw_wait(calm_rx);
				if (hold_req) begin
					hold_req = 1'b0;
					stall += HOLD_CYCLES;
				end
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
				do @(posedge clk); while (!out_valid);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= nstr_pkg::CFG_ATTACHED;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		operation <= nstr_pkg::OP_BEGIN;
		timestamp <= '0;
		use_own_color <= 1'b0;
		color <= '0;
		entry_index <= '0;
		now_tick = rand63();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled until a frame boundary sees attached set
		set_profiler(1'b0, '0);
		send(nstr_pkg::OP_BEGIN, 63'd100, 1'b1, 32'h1234_5678, 6'd0);
		send(nstr_pkg::OP_END, 63'd200, 1'b0, '0, 6'd0);
		send(nstr_pkg::OP_READ, '0, 1'b0, '0, 6'd0);
		drain();
		set_profiler(1'b1, '1);
		send(nstr_pkg::OP_FRAME, '0, 1'b0, '0, 6'd0);
		send(nstr_pkg::OP_BEGIN, '0, 1'b0, '0, 6'd0);
		send(nstr_pkg::OP_BEGIN, nstr_pkg::MASK63, 1'b1, 32'h0, 6'd63);
		send(nstr_pkg::OP_END, 63'd3, 1'b0, '0, 6'd0);
		send(nstr_pkg::OP_END, nstr_pkg::MASK63, 1'b1, '1, 6'd63);
		send(nstr_pkg::OP_BEGIN, 63'd10, 1'b1, 32'hA5C3_3C5A, 6'd0);
		send(nstr_pkg::OP_END, 63'd20, 1'b0, '0, 6'd0);
		send(nstr_pkg::OP_END, 63'd30, 1'b0, '0, 6'd0);
		send(nstr_pkg::OP_BEGIN, 63'd40, 1'b1, '1, 6'd0);
		send(nstr_pkg::OP_FRAME, nstr_pkg::MASK63, 1'b1, '1, 6'd63);
		for (int i = 0; i < 5; i++)
			send(nstr_pkg::OP_READ, '0, 1'b0, '0, 6'(i));
		send(nstr_pkg::OP_READ, nstr_pkg::MASK63, 1'b1, '1, 6'd63);
		drain();

		// fill the table past its end, unwind, and stall the output meanwhile
		set_profiler(1'b1, '0);
		send_noise(nstr_pkg::OP_FRAME, rand63());
		hold_req = 1'b1;
		repeat (70) send_noise(nstr_pkg::OP_BEGIN, next_tick());
		repeat (8) send_noise(nstr_pkg::OP_END, next_tick());
		send_noise(nstr_pkg::OP_FRAME, rand63());
		repeat (6) send(nstr_pkg::OP_READ, rand63(), 1'($urandom_range(0, 1)), $urandom,
			pick_index());
		send(nstr_pkg::OP_READ, '0, 1'b0, '0, 6'd63);

		while (sent < ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				drain();
				set_profiler($urandom_range(0, 5) != 0, pick_color());
			end
			run_frame($urandom_range(1, 20));
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("nested_section_time_recorder_core regression: pass");
		else
			$display("nested_section_time_recorder_core regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/nstr_pkg.sv
sv/nstr_alu.sv
sv/nstr_section_mem.sv
sv/nested_section_time_recorder_core.sv
test/section_recorder_checker.sv
test/tb.sv
